FILE: rtl/isotp_pkg.sv
// shared types, codes and helpers for the iso-tp receive reassembly block
// no dependencies; used by the interfaces, the core, the top level and the checker
`default_nettype none

package isotp_pkg;

  localparam int unsigned MAX_MESSAGE_DEF = 4095;

  localparam int unsigned ID_W      = 29;
  localparam int unsigned LEN_W     = 12;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 29;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RX_ID      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TX_ID      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEP_TIME   = 2'd3;

  // input word kinds
  localparam logic MODE_FRAME  = 1'b0;
  localparam logic MODE_REPORT = 1'b1;

  // pci frame types (upper nibble of byte 0)
  localparam logic [3:0] FT_SINGLE      = 4'h0;
  localparam logic [3:0] FT_FIRST       = 4'h1;
  localparam logic [3:0] FT_CONSECUTIVE = 4'h2;

  // flow status
  localparam logic FS_CONTINUE = 1'b0;
  localparam logic FS_OVFL     = 1'b1;

  // error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_TOO_LONG = 2'd1;
  localparam logic [1:0] ERR_FC_FAIL  = 2'd2;
  localparam logic [1:0] ERR_SEQUENCE = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_SEND_FC = 2'd1,
    PH_WAIT_CF = 2'd2
  } phase_e;

  typedef struct packed {
    logic            mode;
    logic [ID_W-1:0] can_id;
    logic [63:0]     frame_bytes;
    logic [3:0]      frame_length;
    logic            tx_ok;
  } in_word_t;

  typedef struct packed {
    logic             write_valid;
    logic [LEN_W-1:0] write_offset;
    logic [55:0]      write_bytes;
    logic [2:0]       write_count;
    logic             fc_request;
    logic             fc_status;
    logic             message_done;
    logic [LEN_W-1:0] message_length;
    logic [1:0]       error_code;
  } out_word_t;

  typedef struct packed {
    logic [ID_W-1:0] rx_id;
    logic [7:0]      block_size;
  } cfg_t;

  // keep the first count bytes of v, zero the rest
  function automatic logic [55:0] keep_bytes(input logic [55:0] v, input logic [2:0] count);
    logic [55:0] r;
    r = '0;
    for (int i = 0; i < 7; i++) begin
      if (3'(i) < count) begin
        r[8*i +: 8] = v[8*i +: 8];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/isotp_if.sv
// valid/ready channel interfaces for input words and result words
// depends on isotp_pkg for the payload structs
`default_nettype none

interface isotp_in_if import isotp_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface isotp_out_if import isotp_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/isotp_rx_core.sv
// receive state machine and frame decode; one word per enabled cycle
// depends on isotp_pkg
`default_nettype none

module isotp_rx_core import isotp_pkg::*; #(
  parameter int unsigned MaxMessage = MAX_MESSAGE_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      step_i,
  input  wire cfg_t      cfg_i,
  input  wire in_word_t  word_i,
  output      out_word_t result_o
);

  localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MaxMessage);

  phase_e           phase_q, phase_d;
  logic [3:0]       exp_seq_q, exp_seq_d;
  logic [LEN_W-1:0] remain_q, remain_d;
  logic [LEN_W-1:0] total_q, total_d;
  logic [7:0]       blk_cnt_q, blk_cnt_d;
  logic             pend_q, pend_d;

  logic [3:0]       flen, flen_m1, nib, ftype;
  logic             is_frame, is_report;
  logic             sf_hit, ff_hit, ff_ovf, cf_hit, cf_seq_ok;
  logic [LEN_W-1:0] ff_len, cf_remain_after;
  logic [2:0]       cf_avail, cf_count;
  logic [7:0]       blk_next;
  logic             blk_full;

  // shallow decode
  assign flen      = (word_i.frame_length > 4'd8) ? 4'd8 : word_i.frame_length;
  assign flen_m1   = flen - 4'd1;
  assign ftype     = word_i.frame_bytes[7:4];
  assign nib       = word_i.frame_bytes[3:0];
  assign is_report = (word_i.mode == MODE_REPORT) && (phase_q == PH_SEND_FC);
  assign is_frame  = (word_i.mode == MODE_FRAME) && (word_i.can_id == cfg_i.rx_id) &&
                     (word_i.frame_length != 4'd0);

  assign sf_hit = is_frame && (ftype == FT_SINGLE) && (phase_q == PH_IDLE) &&
                  (nib != 4'd0) && (nib <= 4'd7) && (nib <= flen_m1);

  assign ff_len = {nib, word_i.frame_bytes[15:8]};
  assign ff_hit = is_frame && (ftype == FT_FIRST) && (phase_q == PH_IDLE) &&
                  (flen == 4'd8) && (ff_len >= LEN_W'(8));
  assign ff_ovf = ff_len > MaxLen;

  assign cf_hit    = is_frame && (ftype == FT_CONSECUTIVE) && (phase_q == PH_WAIT_CF);
  assign cf_seq_ok = nib == exp_seq_q;
  assign cf_avail  = flen_m1[2:0];
  assign cf_count  = (remain_q < {9'd0, cf_avail}) ? remain_q[2:0] : cf_avail;
  assign cf_remain_after = remain_q - {9'd0, cf_count};
  assign blk_next  = blk_cnt_q + 8'd1;
  assign blk_full  = (cfg_i.block_size != 8'd0) && (blk_next >= cfg_i.block_size);

  // next state
  always_comb begin
    phase_d   = phase_q;
    exp_seq_d = exp_seq_q;
    remain_d  = remain_q;
    total_d   = total_q;
    blk_cnt_d = blk_cnt_q;
    pend_d    = pend_q;
    if (is_report) begin
      if (word_i.tx_ok && (pend_q == FS_CONTINUE)) begin
        phase_d   = PH_WAIT_CF;
        blk_cnt_d = 8'd0;
      end else begin
        phase_d = PH_IDLE;
      end
    end else if (ff_hit) begin
      phase_d = PH_SEND_FC;
      if (ff_ovf) begin
        pend_d = FS_OVFL;
      end else begin
        pend_d    = FS_CONTINUE;
        total_d   = ff_len;
        remain_d  = ff_len - LEN_W'(6);
        exp_seq_d = 4'd1;
        blk_cnt_d = 8'd0;
      end
    end else if (cf_hit) begin
      if (!cf_seq_ok) begin
        remain_d = '0;
        pend_d   = FS_OVFL;
        phase_d  = PH_SEND_FC;
      end else begin
        remain_d = cf_remain_after;
        if (cf_remain_after == '0) begin
          phase_d = PH_IDLE;
        end else begin
          exp_seq_d = exp_seq_q + 4'd1;
          if (cfg_i.block_size != 8'd0) begin
            blk_cnt_d = blk_full ? 8'd0 : blk_next;
            if (blk_full) begin
              pend_d  = FS_CONTINUE;
              phase_d = PH_SEND_FC;
            end
          end
        end
      end
    end
  end

  // result word
  always_comb begin
    result_o = '0;
    if (is_report) begin
      if (!word_i.tx_ok) begin
        result_o.error_code = ERR_FC_FAIL;
      end
    end else if (sf_hit) begin
      result_o.write_valid    = 1'b1;
      result_o.write_bytes    = keep_bytes(word_i.frame_bytes[63:8], nib[2:0]);
      result_o.write_count    = nib[2:0];
      result_o.message_done   = 1'b1;
      result_o.message_length = {8'd0, nib};
    end else if (ff_hit) begin
      result_o.fc_request = 1'b1;
      if (ff_ovf) begin
        result_o.fc_status  = FS_OVFL;
        result_o.error_code = ERR_TOO_LONG;
      end else begin
        result_o.fc_status   = FS_CONTINUE;
        result_o.write_valid = 1'b1;
        result_o.write_bytes = {8'd0, word_i.frame_bytes[63:16]};
        result_o.write_count = 3'd6;
      end
    end else if (cf_hit) begin
      if (!cf_seq_ok) begin
        result_o.fc_request = 1'b1;
        result_o.fc_status  = FS_OVFL;
        result_o.error_code = ERR_SEQUENCE;
      end else begin
        result_o.write_valid  = cf_count != 3'd0;
        result_o.write_offset = total_q - remain_q;
        result_o.write_bytes  = keep_bytes(word_i.frame_bytes[63:8], cf_count);
        result_o.write_count  = cf_count;
        if (cf_remain_after == '0) begin
          result_o.message_done   = 1'b1;
          result_o.message_length = total_q;
        end else if (blk_full) begin
          result_o.fc_request = 1'b1;
          result_o.fc_status  = FS_CONTINUE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      exp_seq_q <= '0;
      remain_q  <= '0;
      total_q   <= '0;
      blk_cnt_q <= '0;
      pend_q    <= FS_CONTINUE;
    end else if (step_i) begin
      phase_q   <= phase_d;
      exp_seq_q <= exp_seq_d;
      remain_q  <= remain_d;
      total_q   <= total_d;
      blk_cnt_q <= blk_cnt_d;
      pend_q    <= pend_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/isotp_receive_reassembly.sv
// iso-tp receive reassembly top level: input register, receive core, result register
// depends on isotp_pkg, isotp_if and isotp_rx_core
//
// usage
//   in_i carries one word per accepted handshake: either a received can frame
//   (mode 0) or the outcome of sending a requested flow control frame (mode 1)
//   out_o returns exactly one result word per input word, in order: a byte
//   write at a message offset, a flow control request, message completion
//   and an error code
//   the config port writes rx_id and block_size; tx_id and sep_time writes are
//   accepted but only matter to the flow control transmitter outside this block
//   write config only while no word is in flight
// timing
//   a word accepted from in_i waits in the input register; decode and state
//   update load the result register when the core steps, which raises out_o.valid
//   and holds the result until out_o.ready takes it
//   throughput is one word per cycle while out_o.ready does not stall; the state
//   update is one pass of decode and 12-bit subtracts, so words follow back to back
// reset
//   rst_ni clears both pipeline valid bits, puts the receiver idle and clears
//   rx_id and block_size
// stalls
//   when out_o.ready is low the result register holds; the input register keeps
//   one word, so in_i.ready drops only once both stages are full
`default_nettype none

module isotp_receive_reassembly import isotp_pkg::*; #(
  parameter int unsigned MaxMessage = MAX_MESSAGE_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  isotp_in_if.sink                  in_i,
  isotp_out_if.source               out_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  // configuration: only the registers that change results are kept here
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RX_ID:      cfg_q.rx_id      <= cfg_data_i[ID_W-1:0];
        CFG_BLOCK_SIZE: cfg_q.block_size <= cfg_data_i[7:0];
        CFG_TX_ID, CFG_SEP_TIME: begin
          // used by the flow control transmitter, nothing to hold here
        end
        default: begin
        end
      endcase
    end
  end

  // input register
  logic     in_valid_q;
  in_word_t in_q;
  // result register
  logic      out_valid_q;
  out_word_t out_q;
  out_word_t result;

  logic step;

  // the core advances whenever a word waits and the result slot is free or draining
  assign step       = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_q <= in_i.data;
    end
  end

  isotp_rx_core #(
    .MaxMessage (MaxMessage)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .cfg_i    (cfg_q),
    .word_i   (in_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= result;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

`default_nettype wire

FILE: rtl/isotp_checker.sv
// port-level checks for the iso-tp receive reassembly block, bound to the top level
// depends on isotp_pkg and isotp_receive_reassembly
`default_nettype none

module isotp_checker import isotp_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      out_valid_i,
  input wire logic      out_ready_i,
  input wire out_word_t out_data_i
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result word changed while stalled");

  // write strobe agrees with the byte count
  a_write_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_i.write_valid == (out_data_i.write_count != 3'd0)))
    else $error("write_valid disagrees with write_count");

  // overflow and sequence errors always ask for an overflow flow control
  a_err_fc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.error_code == ERR_TOO_LONG ||
                    out_data_i.error_code == ERR_SEQUENCE)
    |-> out_data_i.fc_request && (out_data_i.fc_status == FS_OVFL))
    else $error("error without overflow flow control");

  // a completed message carries no error and no flow control request
  a_done_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.message_done
    |-> (out_data_i.error_code == ERR_NONE) && !out_data_i.fc_request &&
        (out_data_i.message_length != '0))
    else $error("message_done with error or flow control");

endmodule

bind isotp_receive_reassembly isotp_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

`default_nettype wire
